@@ design/first_fit_block_allocator_top_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the first-fit block allocator
// Shared implication forms used by the design's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define FFBA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// next-cycle implication
`define FFBA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

@@ design/ffba_pkg.sv @@
// ---------------------------------------------------------------------------
// First-fit block allocator package
// Widths, granule constants and request codes.
// ---------------------------------------------------------------------------
package ffba_pkg;

	localparam int MAX_POOL_BYTES = 4096;
	localparam int GRANULE_BYTES  = 4;
	localparam int DEPTH          = MAX_POOL_BYTES / GRANULE_BYTES;
	localparam int AW             = $clog2(DEPTH);
	localparam int LW             = AW + 1;

	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_REALLOC = 2'd1;
	localparam logic [1:0] KIND_FREE    = 2'd2;

	typedef logic [AW-1:0] gaddr_t;
	typedef logic [LW-1:0] glen_t;

	typedef struct packed {
		logic  busy;
		glen_t len;
	} entry_t;

endpackage

@@ design/first_fit_block_allocator_top.sv @@
// ---------------------------------------------------------------------------
// First-fit block allocator
// Keeps a pool partitioned into free and busy blocks in a granule table and
// serves alloc, realloc and free requests with coalescing of free neighbors.
// ---------------------------------------------------------------------------
//  channel   signals                                  handshake
//  request   kind, block_offset, request_bytes        start & !busy
//  result    granted, result_offset                   done (one cycle)
//  config    cfg_wr_data                              cfg_wr_en
//
//  A request walks the block table through one read port with registered
//  data: each visited block takes a read state and a check state. The
//  worst request, a realloc that grows, makes a first-fit walk and a
//  predecessor walk over the blocks, plus fixed steps and merges.
//  After reset and after every config write a clearing pass over every
//  table entry rewrites the table; busy stays high meanwhile.
//  The result beat cannot be stalled.
// ---------------------------------------------------------------------------
module first_fit_block_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [11:0] block_offset,
	input  logic [12:0] request_bytes,
	output logic        done,
	output logic        granted,
	output logic [11:0] result_offset,
	input  logic        cfg_wr_en,
	input  logic [12:0] cfg_wr_data
);

	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_FB_RD    = 4'd2;
	localparam logic [3:0] S_FB_CHK   = 4'd3;
	localparam logic [3:0] S_AL_RD    = 4'd4;
	localparam logic [3:0] S_AL_CHK   = 4'd5;
	localparam logic [3:0] S_SPLIT    = 4'd6;
	localparam logic [3:0] S_MG_START = 4'd7;
	localparam logic [3:0] S_MG_CHK   = 4'd8;
	localparam logic [3:0] S_MG_CLR   = 4'd9;
	localparam logic [3:0] S_FREE     = 4'd10;
	localparam logic [3:0] S_PV_INIT  = 4'd11;
	localparam logic [3:0] S_PV_RD    = 4'd12;
	localparam logic [3:0] S_PV_CHK   = 4'd13;
	localparam logic [3:0] S_FIN      = 4'd14;

	localparam int AW = ffba_pkg::AW;
	localparam int LW = ffba_pkg::LW;

	ffba_pkg::entry_t mem [ffba_pkg::DEPTH];
	ffba_pkg::entry_t rd_q;

	logic [3:0]       state_q;
	logic [3:0]       ret_q;
	logic [LW-1:0]    pg_q;
	logic [LW-1:0]    clr_q;
	logic [1:0]       kind_q;
	logic             nz_q;
	logic             grow_q;
	ffba_pkg::gaddr_t g_q;
	ffba_pkg::gaddr_t res_q;
	ffba_pkg::gaddr_t mg_q;
	ffba_pkg::glen_t  mlen_q;
	ffba_pkg::glen_t  ulen_q;
	logic [LW-1:0]    p_q;
	logic [LW:0]      r_q;
	logic             done_q;
	logic             granted_q;
	logic [11:0]      roff_q;

	logic             mem_we;
	ffba_pkg::gaddr_t waddr;
	ffba_pkg::gaddr_t raddr;
	ffba_pkg::entry_t wdata;
	logic [LW-1:0]    nx;
	logic [LW-1:0]    pl;
	logic             fits;
	logic [LW-1:0]    cfg_g;
	logic [LW+2:0]    r_sum;
	logic             off_ok;

	assign nx     = {1'b0, mg_q} + mlen_q;
	assign pl     = p_q + rd_q.len;
	assign fits   = !rd_q.busy && ({1'b0, rd_q.len} >= r_q);
	assign r_sum  = {1'b0, request_bytes} + (LW+3)'(ffba_pkg::GRANULE_BYTES);
	assign off_ok = (block_offset[1:0] == 2'b00) && ({1'b0, block_offset[11:2]} < pg_q);

	always_comb begin
		if (cfg_wr_data[12:2] == '0) begin
			cfg_g = LW'(1);
		end else if (cfg_wr_data[12:2] > LW'(ffba_pkg::DEPTH)) begin
			cfg_g = LW'(ffba_pkg::DEPTH);
		end else begin
			cfg_g = cfg_wr_data[12:2];
		end
	end

	always_comb begin
		mem_we = 1'b0;
		waddr  = '0;
		wdata  = '0;
		raddr  = '0;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				waddr  = clr_q[AW-1:0];
				wdata  = (clr_q == '0) ? {1'b0, pg_q} : '0;
			end
			S_FB_RD: raddr = g_q;
			S_FB_CHK: begin
				if (rd_q.len != '0 && rd_q.busy && kind_q != ffba_pkg::KIND_FREE && !nz_q
					&& {1'b0, rd_q.len} > r_q) begin
					mem_we = 1'b1;
					waddr  = g_q;
					wdata  = {1'b1, r_q[LW-1:0]};
				end
			end
			S_AL_RD: raddr = p_q[AW-1:0];
			S_AL_CHK: begin
				if (rd_q.len != '0 && fits) begin
					mem_we = 1'b1;
					waddr  = p_q[AW-1:0];
					wdata  = {1'b1, r_q[LW-1:0]};
				end
			end
			S_SPLIT: begin
				mem_we = 1'b1;
				waddr  = mg_q;
				wdata  = {1'b0, mlen_q};
			end
			S_MG_START: raddr = nx[AW-1:0];
			S_MG_CHK: begin
				if (!rd_q.busy && rd_q.len != '0) begin
					mem_we = 1'b1;
					waddr  = mg_q;
					wdata  = {1'b0, mlen_q + rd_q.len};
				end
			end
			S_MG_CLR: begin
				mem_we = 1'b1;
				waddr  = nx[AW-1:0];
				wdata  = '0;
			end
			S_FREE: begin
				mem_we = 1'b1;
				waddr  = g_q;
				wdata  = {1'b0, ulen_q};
			end
			S_PV_RD: raddr = p_q[AW-1:0];
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			ret_q     <= S_FIN;
			pg_q      <= LW'(ffba_pkg::DEPTH);
			clr_q     <= '0;
			done_q    <= 1'b0;
			granted_q <= 1'b0;
			roff_q    <= '0;
			grow_q    <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			granted_q <= 1'b0;
			roff_q    <= '0;
			if (cfg_wr_en) begin
				pg_q    <= cfg_g;
				clr_q   <= '0;
				state_q <= S_CLEAR;
			end else begin
				case (state_q)
					S_CLEAR: begin
						clr_q <= clr_q + LW'(1);
						if (clr_q == LW'(ffba_pkg::DEPTH - 1)) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (start) begin
							kind_q <= kind;
							nz_q   <= (request_bytes == '0);
							r_q    <= r_sum[LW+2:2];
							g_q    <= block_offset[11:2];
							grow_q <= 1'b0;
							p_q    <= '0;
							if (kind == ffba_pkg::KIND_ALLOC && request_bytes != '0) begin
								state_q <= S_AL_RD;
							end else if ((kind == ffba_pkg::KIND_REALLOC
								|| kind == ffba_pkg::KIND_FREE) && off_ok) begin
								state_q <= S_FB_RD;
							end else begin
								done_q <= 1'b1;
							end
						end
					end
					S_FB_RD: state_q <= S_FB_CHK;
					S_FB_CHK: begin
						ulen_q <= rd_q.len;
						res_q  <= g_q;
						if (rd_q.len == '0 || !rd_q.busy) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (kind_q == ffba_pkg::KIND_FREE || nz_q) begin
							state_q <= S_FREE;
						end else if ({1'b0, rd_q.len} == r_q) begin
							state_q <= S_FIN;
						end else if ({1'b0, rd_q.len} > r_q) begin
							mg_q    <= g_q + r_q[AW-1:0];
							mlen_q  <= rd_q.len - r_q[LW-1:0];
							ret_q   <= S_FIN;
							state_q <= S_SPLIT;
						end else begin
							grow_q  <= 1'b1;
							p_q     <= '0;
							state_q <= S_AL_RD;
						end
					end
					S_AL_RD: begin
						if (p_q >= pg_q) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_AL_CHK;
						end
					end
					S_AL_CHK: begin
						if (rd_q.len == '0) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (fits) begin
							res_q <= p_q[AW-1:0];
							if ({1'b0, rd_q.len} > r_q) begin
								mg_q    <= p_q[AW-1:0] + r_q[AW-1:0];
								mlen_q  <= rd_q.len - r_q[LW-1:0];
								ret_q   <= grow_q ? S_FREE : S_FIN;
								state_q <= S_SPLIT;
							end else begin
								state_q <= grow_q ? S_FREE : S_FIN;
							end
						end else begin
							p_q     <= pl;
							state_q <= S_AL_RD;
						end
					end
					S_SPLIT: state_q <= S_MG_START;
					S_MG_START: begin
						state_q <= (nx >= pg_q) ? ret_q : S_MG_CHK;
					end
					S_MG_CHK: begin
						state_q <= (!rd_q.busy && rd_q.len != '0) ? S_MG_CLR : ret_q;
					end
					S_MG_CLR: state_q <= ret_q;
					S_FREE: begin
						mg_q    <= g_q;
						mlen_q  <= ulen_q;
						ret_q   <= S_PV_INIT;
						state_q <= S_MG_START;
					end
					S_PV_INIT: begin
						p_q     <= '0;
						state_q <= (g_q == '0) ? S_FIN : S_PV_RD;
					end
					S_PV_RD: begin
						state_q <= (p_q >= pg_q) ? S_FIN : S_PV_CHK;
					end
					S_PV_CHK: begin
						if (rd_q.len == '0) begin
							state_q <= S_FIN;
						end else if (pl == {1'b0, g_q}) begin
							if (!rd_q.busy) begin
								mg_q    <= p_q[AW-1:0];
								mlen_q  <= rd_q.len;
								ret_q   <= S_FIN;
								state_q <= S_MG_START;
							end else begin
								state_q <= S_FIN;
							end
						end else begin
							p_q     <= pl;
							state_q <= S_PV_RD;
						end
					end
					S_FIN: begin
						done_q    <= 1'b1;
						granted_q <= 1'b1;
						roff_q    <= {res_q, 2'b00};
						state_q   <= S_IDLE;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign granted       = granted_q;
	assign result_offset = roff_q;

	`include "first_fit_block_allocator_top_macros.svh"

	`FFBA_ASSERT_NXT(a_start_goes_busy, start && !busy && !cfg_wr_en, busy || done)
	`FFBA_ASSERT_IMP(a_quiet_result, !done, !granted && result_offset == '0)
	`FFBA_ASSERT_IMP(a_no_result_in_clear, state_q == S_CLEAR, !granted)
	`FFBA_ASSERT_IMP(a_pool_range, 1'b1, pg_q != '0 && pg_q <= LW'(ffba_pkg::DEPTH))

endmodule
